/* design/hcl_pkg.sv */
// Shared constants, fixed-point helpers and table generators for the HCL to sRGB converter.
package hcl_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int GAMMA_BITS_DEF = 10;
  // Integer bits above the fraction, sign included; the linear RGB sums stay within +-64.
  localparam int INT_BITS       = 8;
  localparam int SIN_LAT        = 16;
  localparam int SIN_STEPS      = 6;

  // Constants in Q30.
  localparam longint K_0_61     = 654982185;
  localparam longint K_0_09     = 96636764;
  localparam longint K_0_311    = 333933707;
  localparam longint K_0_125    = 134217728;
  localparam longint K_25_29    = 925639503;
  localparam longint K_4_29     = 148102321;
  localparam longint K_6_29     = 222153481;
  localparam longint K_108_841  = 137888367;
  localparam longint K_0_2      = 214748365;
  localparam longint K_XN       = 1035312604;
  localparam longint K_ZN       = 886041016;
  localparam longint K_0_001    = 1073742;
  localparam longint K_LIN_THR  = 3361671;
  localparam longint K_12_92    = 64'd13872744366;
  localparam longint K_1_055    = 1132797624;
  localparam longint K_0_055    = 59055800;
  localparam longint K_HALF_PI  = 1686629713;
  localparam logic [31:0] K_SIXTH_TURN = 32'd715827883;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam longint RGB_MAT [3][3] = '{
    '{ 64'sd3479567755, -64'sd1650555932,  -64'sd535367673},
    '{-64'sd1040348453,  64'sd2014124913,    64'sd44560286},
    '{   64'sd59807420,  -64'sd219043332,  64'sd1134945108}
  };

  // Divisors of the nested Taylor form of the quarter-wave sine.
  localparam longint SIN_DIVS [SIN_STEPS] = '{156, 110, 72, 42, 20, 6};

  // Shift right with rounding half toward plus infinity.
  function automatic longint rshr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint mulc(longint a, longint c30);
    return rshr(a * c30, 30);
  endfunction

  function automatic longint mulf(longint a, longint b, int f);
    return rshr(a * b, f);
  endfunction

  function automatic longint cf(longint c30, int f);
    return rshr(c30, 30 - f);
  endfunction

  function automatic longint unsigned isqrt64(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    longint unsigned m;
    r = 0;
    b = 64'd1 << 62;
    m = n;
    while (b > m) b = b >> 2;
    while (b != 0) begin
      if (m >= r + b) begin
        m = m - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned icbrt64(longint unsigned n);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd1 << 21;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Gamma curve sample i of 2^g, in f fraction bits; evaluated at elaboration only.
  function automatic longint gamma_entry(longint unsigned i, int f, int g);
    longint unsigned v30;
    longint unsigned v20;
    longint unsigned q;
    longint unsigned e;
    longint unsigned p;
    longint g30;
    v30 = i << (30 - g);
    if (v30 <= longint'(K_LIN_THR))
      return rshr(longint'((v30 * K_12_92) >> 30), 30 - f);
    v20 = i << (20 - g);
    q = isqrt64(isqrt64(v20 << 20) << 20);
    e = isqrt64(icbrt64(v20 << 40) << 20);
    p = (q * e) >> 20;
    g30 = longint'((p * K_1_055) >> 20) - K_0_055;
    return rshr(g30, 30 - f);
  endfunction

endpackage

/* design/hcl_ram.sv */
// Generic RAM with one write port and two registered read ports.
module hcl_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

/* design/hcl_sin.sv */
// Pipelined sine of a 32-bit phase: quadrant fold, six-step Taylor polynomial, rounding.
module hcl_sin import hcl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [31:0]                            phase,
  output logic signed [FRAC_BITS+INT_BITS-1:0]   sine
);

  localparam int W = FRAC_BITS + INT_BITS;
  localparam logic [30:0] ONE30 = 31'h4000_0000;

  logic [30:0] fq;
  logic [61:0] fx;
  logic [30:0] x1;
  logic        n1;
  logic [61:0] sq;
  logic [30:0] x2_x;
  logic [31:0] x2_1;
  logic        n2;

  logic [31:0] va  [SIN_STEPS];
  logic [30:0] xa  [SIN_STEPS];
  logic [31:0] x2a [SIN_STEPS];
  logic        na  [SIN_STEPS];
  logic [30:0] tb  [SIN_STEPS];
  logic [30:0] xb  [SIN_STEPS];
  logic [31:0] x2b [SIN_STEPS];
  logic        nb  [SIN_STEPS];

  logic [61:0] st;
  logic [30:0] s_r;
  logic        n_f;

  // Odd quadrants run the quarter wave backwards.
  assign fq = phase[30] ? (ONE30 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
  assign fx = 62'(fq) * 62'(K_HALF_PI);
  assign sq = 62'(x1) * 62'(x1);

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= fx[60:30];
      n1   <= phase[31];
      x2_x <= x1;
      x2_1 <= sq[61:30];
      n2   <= n1;
    end
  end

  for (genvar k = 0; k < SIN_STEPS; k++) begin : g_step
    localparam logic [39:0] MK =
      40'(((longint'(1) <<< 40) + SIN_DIVS[k] - 1) / SIN_DIVS[k]);
    logic [30:0] t_in;
    logic [30:0] x_in;
    logic [31:0] x2_in;
    logic        n_in;
    logic [62:0] pm;
    logic [71:0] pq;

    if (k == 0) begin : g_first
      assign t_in  = ONE30;
      assign x_in  = x2_x;
      assign x2_in = x2_1;
      assign n_in  = n2;
    end else begin : g_next
      assign t_in  = tb[k-1];
      assign x_in  = xb[k-1];
      assign x2_in = x2b[k-1];
      assign n_in  = nb[k-1];
    end

    assign pm = 63'(x2_in) * 63'(t_in);
    // Reciprocal multiply gives the exact floor quotient for any 32-bit dividend.
    assign pq = 72'(va[k]) * 72'(MK);

    always_ff @(posedge clk) begin
      if (en) begin
        va[k]  <= pm[61:30];
        xa[k]  <= x_in;
        x2a[k] <= x2_in;
        na[k]  <= n_in;
        tb[k]  <= ONE30 - pq[70:40];
        xb[k]  <= xa[k];
        x2b[k] <= x2a[k];
        nb[k]  <= na[k];
      end
    end
  end

  assign st = 62'(xb[SIN_STEPS-1]) * 62'(tb[SIN_STEPS-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      s_r  <= st[60:30];
      n_f  <= nb[SIN_STEPS-1];
      sine <= W'(rshr(n_f ? -longint'(s_r) : longint'(s_r), 30 - FRAC_BITS));
    end
  end

endmodule

/* design/hcl_finv.sv */
// Inverse Lab cube function for one channel, followed by the white point scale when SCALED is set.
module hcl_finv import hcl_pkg::*; #(
  parameter int     FRAC_BITS = FRAC_BITS_DEF,
  parameter bit     SCALED    = 1'b1,
  parameter longint SCALE     = K_XN
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [FRAC_BITS+INT_BITS-1:0] t,
  output logic signed [FRAC_BITS+INT_BITS-1:0] f_out
);

  localparam int W = FRAC_BITS + INT_BITS;
  localparam logic signed [W-1:0] C4 = W'(cf(K_4_29, FRAC_BITS));
  localparam logic signed [W-1:0] C6 = W'(cf(K_6_29, FRAC_BITS));

  logic signed [W-1:0] sq;
  logic signed [W-1:0] lin;
  logic signed [W-1:0] t1;
  logic                sel;
  logic signed [W-1:0] fv;

  always_ff @(posedge clk) begin
    if (en) begin
      sq    <= W'(mulf(longint'(t), longint'(t), FRAC_BITS));
      lin   <= W'(mulc(longint'(t - C4), K_108_841));
      sel   <= t > C6;
      t1    <= t;
      fv    <= sel ? W'(mulf(longint'(sq), longint'(t1), FRAC_BITS)) : lin;
      f_out <= SCALED ? W'(mulc(longint'(fv), SCALE)) : fv;
    end
  end

endmodule

/* design/hcl_enc.sv */
// Gamma encoding of one linear channel: clamp, table lookup with interpolation, 8-bit code.
module hcl_enc import hcl_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int GAMMA_BITS = GAMMA_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic                                 we,
  input  logic [GAMMA_BITS:0]                  waddr,
  input  logic [FRAC_BITS+1:0]                 wdata,
  input  logic signed [FRAC_BITS+INT_BITS-1:0] lin,
  output logic [7:0]                           code
);

  localparam int W    = FRAC_BITS + INT_BITS;
  localparam int GW   = FRAC_BITS + 2;
  localparam int AW   = GAMMA_BITS + 1;
  localparam int UW   = FRAC_BITS + 1 + GAMMA_BITS;
  localparam int LAST = 1 << GAMMA_BITS;
  localparam logic signed [W-1:0] ONE_W = W'(longint'(1) <<< FRAC_BITS);

  logic [FRAC_BITS:0]   cc;
  logic [UW-1:0]        u;
  logic [AW-1:0]        idx;
  logic [AW-1:0]        a0;
  logic [AW-1:0]        a1;
  logic [FRAC_BITS-1:0] fr1;
  logic [FRAC_BITS-1:0] fr2;
  logic [GW-1:0]        g0;
  logic [GW-1:0]        g1;
  logic signed [GW-1:0] g;
  longint               cv;

  always_comb begin
    if (lin < 0) cc = '0;
    else if (lin > ONE_W) cc = ONE_W[FRAC_BITS:0];
    else cc = lin[FRAC_BITS:0];
  end

  assign u   = {cc, {GAMMA_BITS{1'b0}}};
  assign idx = u[UW-1:FRAC_BITS];

  // The full-scale input reads the last entry with no interpolation.
  always_ff @(posedge clk) begin
    if (en) begin
      if (idx[GAMMA_BITS]) begin
        a0  <= AW'(LAST);
        a1  <= AW'(LAST);
        fr1 <= '0;
      end else begin
        a0  <= idx;
        a1  <= idx + 1'b1;
        fr1 <= u[FRAC_BITS-1:0];
      end
      fr2 <= fr1;
    end
  end

  hcl_ram #(.WIDTH(GW), .DEPTH(LAST + 1)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (en),
    .raddr0(a0),
    .raddr1(a1),
    .rdata0(g0),
    .rdata1(g1)
  );

  assign cv = rshr(255 * longint'(g), FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      g <= GW'(longint'($signed(g0)) + rshr((longint'($signed(g1)) - longint'($signed(g0)))
                                            * longint'(fr2), FRAC_BITS));
      if (cv < 0) code <= 8'd0;
      else if (cv > 255) code <= 8'd255;
      else code <= cv[7:0];
    end
  end

endmodule

/* design/hcl_to_srgb_pixel.sv */
// HCL to sRGB pixel converter, top level.
// Converts one HCL colour per clock into 8-bit sRGB with an in-gamut alpha (255 in gamut, 0
// clipped). Most of the pipeline registers lie in the sine and cosine units, whose six
// Taylor steps each take one multiply and one reciprocal multiply. The whole pipeline
// advances together: while m_tready is low with a result waiting, s_tready drops and
// nothing moves. After reset the three gamma RAMs are loaded, one entry per cycle, with
// all 2^GAMMA_TABLE_BITS + 1 entries (1025 at the default); s_tready stays low until that
// pass is done.
module hcl_to_srgb_pixel import hcl_pkg::*; #(
  parameter int FRAC_BITS        = FRAC_BITS_DEF,
  parameter int GAMMA_TABLE_BITS = GAMMA_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // hue_turn[15:0], chroma[31:16], lightness[47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
);

  localparam int W    = FRAC_BITS + INT_BITS;
  localparam int GW   = FRAC_BITS + 2;
  localparam int LAST = 1 << GAMMA_TABLE_BITS;
  localparam int DLY  = SIN_LAT - 2;
  localparam int LAT  = SIN_LAT + 12;
  localparam logic signed [W-1:0] ONE_W = W'(longint'(1) <<< FRAC_BITS);
  localparam logic signed [W-1:0] LO_W  = W'(cf(K_0_001, FRAC_BITS));

  typedef logic [GW-1:0] gtab_t [LAST + 1];

  function automatic gtab_t build_gtab();
    gtab_t tab;
    for (int i = 0; i <= LAST; i++)
      tab[i] = GW'(gamma_entry(longint'(i), FRAC_BITS, GAMMA_TABLE_BITS));
    return tab;
  endfunction

  localparam gtab_t GTAB = build_gtab();

  logic                    en;
  logic                    vld [LAT];
  logic                    fill_busy;
  logic [GAMMA_TABLE_BITS:0] fill_cnt;

  logic [31:0]         ph_s;
  logic [31:0]         ph_c;
  logic signed [W-1:0] cr;
  logic signed [W-1:0] lt;
  logic signed [W-1:0] l2;
  logic signed [W-1:0] rr2;
  logic signed [W-1:0] cr2;
  logic signed [W-1:0] sl_d [DLY+1];
  logic signed [W-1:0] r_d  [DLY+1];
  logic signed [W-1:0] sn;
  logic signed [W-1:0] cs;
  logic signed [W-1:0] a;
  logic signed [W-1:0] b;
  logic signed [W-1:0] sl18;
  logic signed [W-1:0] targ [3];
  logic signed [W-1:0] xyz  [3];
  logic signed [W-1:0] prod [3][3];
  logic signed [W-1:0] lin  [3];
  logic                clip;
  logic                clip_d [4];
  logic [7:0]          code [3];
  logic [31:0]         ph_in;

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en && !fill_busy;
  assign m_tvalid = vld[LAT-1];
  assign m_tdata  = {clip_d[3] ? 8'd0 : 8'd255, code[2], code[1], code[0]};
  assign ph_in    = K_SIXTH_TURN - {s_tdata[15:0], 16'h0000};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_busy <= 1'b1;
      fill_cnt  <= '0;
    end else if (fill_busy) begin
      fill_cnt <= fill_cnt + 1'b1;
      if (fill_cnt == (GAMMA_TABLE_BITS+1)'(LAST)) fill_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid && s_tready;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // Front end: input scaling, sine and cosine phases, Lab lightness and radius.
  always_ff @(posedge clk) begin
    if (en) begin
      ph_s <= ph_in;
      ph_c <= ph_in + QUARTER_TURN;
      cr   <= W'(rshr(longint'(s_tdata[31:16]) <<< FRAC_BITS, 15));
      lt   <= W'(rshr(longint'(s_tdata[47:32]) <<< FRAC_BITS, 15));
      l2   <= W'(mulc(longint'(lt), K_0_61) + cf(K_0_09, FRAC_BITS));
      rr2  <= W'(mulc(longint'(lt), K_0_311) + cf(K_0_125, FRAC_BITS));
      cr2  <= cr;
      r_d[0]  <= W'(mulf(longint'(rr2), longint'(cr2), FRAC_BITS));
      sl_d[0] <= W'(mulc(longint'(l2), K_25_29) + cf(K_4_29, FRAC_BITS));
      for (int i = 1; i <= DLY; i++) begin
        r_d[i]  <= r_d[i-1];
        sl_d[i] <= sl_d[i-1];
      end
    end
  end

  hcl_sin #(.FRAC_BITS(FRAC_BITS)) u_sin (
    .clk(clk), .en(en), .phase(ph_s), .sine(sn)
  );

  hcl_sin #(.FRAC_BITS(FRAC_BITS)) u_cos (
    .clk(clk), .en(en), .phase(ph_c), .sine(cs)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      a       <= W'(mulf(longint'(sn), longint'(r_d[DLY]), FRAC_BITS));
      b       <= W'(mulf(longint'(cs), longint'(r_d[DLY]), FRAC_BITS));
      sl18    <= sl_d[DLY];
      targ[0] <= sl18 + W'(mulc(longint'(a), K_0_2));
      targ[1] <= sl18;
      targ[2] <= sl18 - W'(rshr(longint'(b), 1));
    end
  end

  hcl_finv #(.FRAC_BITS(FRAC_BITS), .SCALED(1'b1), .SCALE(K_XN)) u_finv_x (
    .clk(clk), .en(en), .t(targ[0]), .f_out(xyz[0])
  );

  hcl_finv #(.FRAC_BITS(FRAC_BITS), .SCALED(1'b0), .SCALE(K_XN)) u_finv_y (
    .clk(clk), .en(en), .t(targ[1]), .f_out(xyz[1])
  );

  hcl_finv #(.FRAC_BITS(FRAC_BITS), .SCALED(1'b1), .SCALE(K_ZN)) u_finv_z (
    .clk(clk), .en(en), .t(targ[2]), .f_out(xyz[2])
  );

  // XYZ to linear RGB, then the gamut test on all three channels.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++)
        for (int j = 0; j < 3; j++)
          prod[c][j] <= W'(mulc(longint'(xyz[j]), RGB_MAT[c][j]));
      for (int c = 0; c < 3; c++)
        lin[c] <= prod[c][0] + prod[c][1] + prod[c][2];
      clip <= 1'b0;
      for (int c = 0; c < 3; c++)
        if ((prod[c][0] + prod[c][1] + prod[c][2] < -LO_W) ||
            (prod[c][0] + prod[c][1] + prod[c][2] > ONE_W + LO_W))
          clip <= 1'b1;
      // The gamut flag passes through clip_d[0] to clip_d[3] so that it stays aligned with the gamma stage.
      clip_d[0] <= clip;
      clip_d[1] <= clip_d[0];
      clip_d[2] <= clip_d[1];
      clip_d[3] <= clip_d[2];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_enc
    hcl_enc #(.FRAC_BITS(FRAC_BITS), .GAMMA_BITS(GAMMA_TABLE_BITS)) u_enc (
      .clk  (clk),
      .en   (en),
      .we   (fill_busy),
      .waddr(fill_cnt),
      .wdata(GTAB[fill_cnt]),
      .lin  (lin[c]),
      .code (code[c])
    );
  end

endmodule

/* design/hcl_chk.sv */
// Port-level checks for the HCL to sRGB converter, bound to the top level.
module hcl_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result keeps its value until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Alpha only ever carries the two gamut codes.
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:24] == 8'd0 || m_tdata[31:24] == 8'hFF))
    else $error("alpha is neither 0 nor 255");

  // A blocked output stalls the whole pipeline, so no request may enter.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  // Right after reset the gamma tables are loading: no request is taken and no result shows.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_tready && !m_tvalid)
    else $error("activity while the gamma tables load");

endmodule

bind hcl_to_srgb_pixel hcl_chk u_chk (.*);
